// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define BVS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define BVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bvs_pkg.sv =====
// types and constants of the batched vector similarity block
`default_nettype none

package bvs_pkg;

    localparam int ELEM_W  = 16;
    localparam int OPND_W  = ELEM_W + 1;
    localparam int TERM_W  = 2 * OPND_W;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = ACC_W + 1;
    localparam int LANES   = 4;
    localparam int OUT_DLY = LANES - 1;

    localparam logic MODE_DOT  = 1'b0;
    localparam logic MODE_DIST = 1'b1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ELEM_W-1:0] query_element;
        logic signed [ELEM_W-1:0] cand_a_element;
        logic signed [ELEM_W-1:0] cand_b_element;
        logic signed [ELEM_W-1:0] cand_c_element;
        logic signed [ELEM_W-1:0] cand_d_element;
        logic                     last_element;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] score_a;
        logic signed [ACC_W-1:0] score_b;
        logic signed [ACC_W-1:0] score_c;
        logic signed [ACC_W-1:0] score_d;
    } t_out;

    // request travelling along the row of cells
    typedef struct packed {
        logic  valid;
        logic  mode;
        logic  last;
        t_elem q;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/batch_vector_similarity.sv =====
// top level: four-lane dot product / squared distance engine built as a row of cells
// usage:
//   input channel i_in_valid / o_in_stall carries one element of the query and of
//   the four candidates; i_in_data.last_element closes the vectors
//   output channel o_out_valid / i_out_stall carries the four saturated scores,
//   one result per closed vector
//   config channel i_cfg_valid / o_cfg_ready writes metric_mode (0 inner product,
//   1 squared distance); o_cfg_ready is always high and the mode is captured
//   with each accepted request
// timing:
//   while o_in_stall is low, one request per cycle is sustained; the request
//   enters cell 0 and its query walks one cell per cycle while not stalled,
//   candidate elements skewed to meet it; the last element walks the 4 cells and
//   its result is then registered in the output register, which drives o_out_valid
// stalling:
//   a waiting result does not block input; o_in_stall rises only when a new
//   result reaches the end of the row while the output register is still held
// reset:
//   clears the accumulators, the mode and all valid flags; no clearing pass
`default_nettype none

module batch_vector_similarity (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bvs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bvs_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam int LANES = bvs_pkg::LANES;

    logic           r_mode;
    logic           r_out_valid;
    bvs_pkg::t_out  r_out_data;

    logic           w_adv;
    logic           w_arrive;
    bvs_pkg::t_tok  w_tok   [LANES];
    bvs_pkg::t_elem w_cand  [LANES];
    bvs_pkg::t_elem w_cskew [LANES];
    bvs_pkg::t_acc  w_score [LANES];
    bvs_pkg::t_acc  w_align [LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bvs_pkg::MODE_DOT;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    assign o_in_stall = r_out_valid & i_out_stall & w_arrive;
    assign w_adv      = ~o_in_stall;

    assign w_tok[0].valid = i_in_valid & ~o_in_stall;
    assign w_tok[0].mode  = r_mode;
    assign w_tok[0].last  = i_in_data.last_element;
    assign w_tok[0].q     = i_in_data.query_element;

    assign w_cand[0] = i_in_data.cand_a_element;
    assign w_cand[1] = i_in_data.cand_b_element;
    assign w_cand[2] = i_in_data.cand_c_element;
    assign w_cand[3] = i_in_data.cand_d_element;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            // input skew: lane g's candidate is delayed in a shift line so that it meets its query at cell g
            if (g == 0) begin : g_noskew
                assign w_cskew[g] = w_cand[g];
            end else begin : g_skew
                bvs_pkg::t_elem r_line [g];
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        r_line[0] <= w_cand[g];
                        for (int k = 1; k < g; k++) begin
                            r_line[k] <= r_line[k-1];
                        end
                    end
                end
                assign w_cskew[g] = r_line[g-1];
            end

            if (g < LANES - 1) begin : g_mid
                bvs_cell u_cell (
                    .i_clk         (i_clk),
                    .i_rst_n       (i_rst_n),
                    .i_adv         (w_adv),
                    .i_tok         (w_tok[g]),
                    .i_cand        (w_cskew[g]),
                    .o_tok         (w_tok[g+1]),
                    .o_score_valid (),
                    .o_score       (w_score[g])
                );
            end else begin : g_end
                bvs_cell u_cell (
                    .i_clk         (i_clk),
                    .i_rst_n       (i_rst_n),
                    .i_adv         (w_adv),
                    .i_tok         (w_tok[g]),
                    .i_cand        (w_cskew[g]),
                    .o_tok         (),
                    .o_score_valid (w_arrive),
                    .o_score       (w_score[g])
                );
            end

            // output deskew: earlier lanes wait for the last one
            if (g == LANES - 1) begin : g_nodsk
                assign w_align[g] = w_score[g];
            end else begin : g_dsk
                bvs_pkg::t_acc r_dsk [LANES-1-g];
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        r_dsk[0] <= w_score[g];
                        for (int k = 1; k < LANES - 1 - g; k++) begin
                            r_dsk[k] <= r_dsk[k-1];
                        end
                    end
                end
                assign w_align[g] = r_dsk[LANES-2-g];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv & w_arrive) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv & w_arrive) begin
            r_out_data.score_a <= w_align[0];
            r_out_data.score_b <= w_align[1];
            r_out_data.score_c <= w_align[2];
            r_out_data.score_d <= w_align[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/bvs_cell.sv =====
// one lane cell: multiply or square the difference, then saturating accumulate
`default_nettype none

module bvs_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  bvs_pkg::t_tok  i_tok,
    input  bvs_pkg::t_elem i_cand,
    output bvs_pkg::t_tok  o_tok,
    output logic           o_score_valid,
    output bvs_pkg::t_acc  o_score
);

    bvs_pkg::t_tok  r_tok;
    bvs_pkg::t_term r_prod;
    logic           r_pvalid;
    logic           r_plast;
    bvs_pkg::t_acc  r_acc;
    bvs_pkg::t_acc  n_acc;
    bvs_pkg::t_acc  r_score;
    logic           r_svalid;

    bvs_pkg::t_opnd w_q;
    bvs_pkg::t_opnd w_c;
    bvs_pkg::t_opnd w_diff;
    bvs_pkg::t_opnd w_x;
    bvs_pkg::t_opnd w_y;
    bvs_pkg::t_term w_prod;
    bvs_pkg::t_sum  w_sum;

    assign w_q    = {i_tok.q[bvs_pkg::ELEM_W-1], i_tok.q};
    assign w_c    = {i_cand[bvs_pkg::ELEM_W-1], i_cand};
    assign w_diff = w_q - w_c;
    assign w_x    = (i_tok.mode == bvs_pkg::MODE_DIST) ? w_diff : w_q;
    assign w_y    = (i_tok.mode == bvs_pkg::MODE_DIST) ? w_diff : w_c;
    assign w_prod = w_x * w_y;

    assign w_sum = {r_acc[bvs_pkg::ACC_W-1], r_acc}
                 + {{(bvs_pkg::SUM_W-bvs_pkg::TERM_W){r_prod[bvs_pkg::TERM_W-1]}}, r_prod};

    // clamp to the accumulator range
    always_comb begin
        if (w_sum[bvs_pkg::SUM_W-1] != w_sum[bvs_pkg::SUM_W-2]) begin
            n_acc = w_sum[bvs_pkg::SUM_W-1] ? bvs_pkg::ACC_MIN : bvs_pkg::ACC_MAX;
        end else begin
            n_acc = w_sum[bvs_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_pvalid <= 1'b0;
            r_plast  <= 1'b0;
            r_acc    <= '0;
            r_svalid <= 1'b0;
        end else if (i_adv) begin
            r_tok    <= i_tok;
            r_pvalid <= i_tok.valid;
            r_plast  <= i_tok.last;
            r_svalid <= r_pvalid & r_plast;
            if (r_pvalid) begin
                r_acc <= r_plast ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= w_prod;
            if (r_pvalid & r_plast) begin
                r_score <= n_acc;
            end
        end
    end

    assign o_tok         = r_tok;
    assign o_score_valid = r_svalid;
    assign o_score       = r_score;

endmodule

`default_nettype wire

// ===== rtl/bvs_checker.sv =====
// port checker for the batched vector similarity block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module bvs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bvs_pkg::t_out o_out_data
);

    `BVS_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `BVS_ASSERT(a_out_stable, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> $stable(o_out_data), "stalled result changed")
    `BVS_ASSERT_ALWAYS(a_rst_clear, i_clk,
        !i_rst_n |=> !o_out_valid, "result valid after reset")
    `BVS_ASSERT_ALWAYS(a_stall_cause, i_clk,
        o_in_stall |-> o_out_valid && i_out_stall, "input stalled with output free")

endmodule

bind batch_vector_similarity bvs_checker u_bvs_checker (.*);

`default_nettype wire

// ===== bench/batch_vector_similarity_test.sv =====
// self-checking bench for the four-lane dot product / squared distance engine
module batch_vector_similarity_test;

    localparam longint SUM_TOP    = (longint'(1) << 47) - 1;
    localparam longint SUM_BOTTOM = -(longint'(1) << 47);
    localparam int     SETTLE_CYCLES = 10;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          i_in_valid   = 1'b0;
    bvs_pkg::t_in  i_in_data    = '0;
    logic          i_out_stall  = 1'b0;
    logic          i_cfg_valid  = 1'b0;
    logic          i_cfg_data   = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic          o_cfg_ready;
    bvs_pkg::t_out o_out_data;

    bvs_pkg::t_in  pending_items[$];
    bvs_pkg::t_out expected_scores[$];
    longint        lane_sum[bvs_pkg::LANES] = '{default: 0};
    logic          metric_sel = bvs_pkg::MODE_DOT;

    int error_count = 0;
    int idle_max    = 5;
    int hold_left   = 0;
    int in_gap      = 0;
    int out_wait    = 0;
    bit in_fired    = 1'b0;
    bit out_fired   = 1'b0;

    batch_vector_similarity dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("score check: %s", msg);
        error_count++;
    endtask

    // adds one request's terms to every lane under the current metric
    task automatic accumulate_lanes(input bvs_pkg::t_in item);
        bvs_pkg::t_elem cand[bvs_pkg::LANES];
        bvs_pkg::t_elem qe;
        longint         q;
        longint         c;
        longint         d;
        longint         term;
        longint         s;
        bvs_pkg::t_out  res;
        qe = item.query_element;
        cand[0] = item.cand_a_element;
        cand[1] = item.cand_b_element;
        cand[2] = item.cand_c_element;
        cand[3] = item.cand_d_element;
        q = qe;
        for (int i = 0; i < bvs_pkg::LANES; i++) begin
            c = cand[i];
            if (metric_sel == bvs_pkg::MODE_DIST) begin
                d = q - c;
                term = d * d;
            end else begin
                term = q * c;
            end
            s = lane_sum[i] + term;
            if (s > SUM_TOP) s = SUM_TOP;
            if (s < SUM_BOTTOM) s = SUM_BOTTOM;
            lane_sum[i] = s;
        end
        if (item.last_element) begin
            res.score_a = lane_sum[0][bvs_pkg::ACC_W-1:0];
            res.score_b = lane_sum[1][bvs_pkg::ACC_W-1:0];
            res.score_c = lane_sum[2][bvs_pkg::ACC_W-1:0];
            res.score_d = lane_sum[3][bvs_pkg::ACC_W-1:0];
            expected_scores.push_back(res);
            lane_sum = '{default: 0};
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        logic         nxt_valid;
        bvs_pkg::t_in nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_fired) begin
                in_fired  = 1'b0;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() != 0) begin
                    nxt_item  = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    in_gap    = $urandom_range(0, idle_max);
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_item;
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_fired) begin
                out_fired = 1'b0;
                out_wait  = $urandom_range(0, idle_max);
            end
            if (hold_left > 0) hold_left--;
            i_out_stall <= (hold_left > 0) || (out_wait > 0);
            if (out_wait > 0) out_wait--;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bvs_pkg::t_out want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) metric_sel = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                accumulate_lanes(i_in_data);
                in_fired = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                out_fired = 1'b1;
                if (expected_scores.size() == 0) begin
                    report_error("result with nothing outstanding");
                end else begin
                    want = expected_scores.pop_front();
                    if (o_out_data.score_a !== want.score_a)
                        report_error($sformatf("score_a got %0d want %0d",
                                               o_out_data.score_a, want.score_a));
                    if (o_out_data.score_b !== want.score_b)
                        report_error($sformatf("score_b got %0d want %0d",
                                               o_out_data.score_b, want.score_b));
                    if (o_out_data.score_c !== want.score_c)
                        report_error($sformatf("score_c got %0d want %0d",
                                               o_out_data.score_c, want.score_c));
                    if (o_out_data.score_d !== want.score_d)
                        report_error($sformatf("score_d got %0d want %0d",
                                               o_out_data.score_d, want.score_d));
                end
            end
        end
    end

    function automatic bvs_pkg::t_elem pick_element();
        case ($urandom_range(0, 7))
            0:       return bvs_pkg::t_elem'(-32768);
            1:       return bvs_pkg::t_elem'(32767);
            2:       return '0;
            3:       return bvs_pkg::t_elem'($urandom_range(0, 8) - 4);
            default: return bvs_pkg::t_elem'($urandom());
        endcase
    endfunction

    function automatic bvs_pkg::t_in make_item(input int q, input int a, input int b,
                                               input int c, input int d, input bit last);
        bvs_pkg::t_in item;
        item.query_element  = bvs_pkg::t_elem'(q);
        item.cand_a_element = bvs_pkg::t_elem'(a);
        item.cand_b_element = bvs_pkg::t_elem'(b);
        item.cand_c_element = bvs_pkg::t_elem'(c);
        item.cand_d_element = bvs_pkg::t_elem'(d);
        item.last_element   = last;
        return item;
    endfunction

    task automatic queue_vector(input int len, input bit closed);
        bvs_pkg::t_in item;
        for (int k = 0; k < len; k++) begin
            item.query_element  = pick_element();
            item.cand_a_element = pick_element();
            item.cand_b_element = pick_element();
            item.cand_c_element = pick_element();
            item.cand_d_element = pick_element();
            item.last_element   = closed && (k == len - 1);
            pending_items.push_back(item);
        end
    endtask

    // all requests taken, all results back, pipeline empty
    task automatic settle();
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        for (int w = 0; w < 4000 && expected_scores.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode_bit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode_bit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        bvs_pkg::t_in item;
        int           phase_items;
        int           len;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single-element vectors, metric switch mid-vector
        idle_max = 5;
        write_mode(bvs_pkg::MODE_DOT);
        pending_items.push_back(make_item(-32768, -32768, 32767, 0, 1, 1));
        pending_items.push_back(make_item(32767, 32767, -32768, -1, 32767, 1));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(-32768, -32768, -32768, -32768, -32768, 0));
        pending_items.push_back(make_item(32767, -32768, 32767, 1, -1, 0));
        settle();
        write_mode(bvs_pkg::MODE_DIST);
        pending_items.push_back(make_item(32767, -32768, 32767, -32768, 0, 1));
        pending_items.push_back(make_item(-32768, 32767, -32768, 0, -1, 1));
        pending_items.push_back(make_item(1, -1, 2, -2, 0, 0));
        pending_items.push_back(make_item(-3, 4, -5, 6, 32767, 0));
        pending_items.push_back(make_item(100, -100, 0, 1000, -1000, 1));
        pending_items.push_back(make_item(5, 5, 5, 5, 5, 0));
        settle();
        write_mode(bvs_pkg::MODE_DOT);
        pending_items.push_back(make_item(7, -7, 1, 0, -32768, 1));
        settle();

        // vectors of extreme and random elements, back to back
        idle_max = 0;
        write_mode(bvs_pkg::MODE_DIST);
        for (int k = 0; k < 24; k++) begin
            item = make_item(32767, -32768, -32768, 0, 0, k == 23);
            item.cand_c_element = pick_element();
            item.cand_d_element = pick_element();
            pending_items.push_back(item);
        end
        settle();
        write_mode(bvs_pkg::MODE_DOT);
        for (int k = 0; k < 24; k++) begin
            item = make_item(-32768, -32768, 32767, 0,
                             k[0] ? 32767 : -32768, k == 23);
            item.cand_c_element = pick_element();
            pending_items.push_back(item);
        end
        settle();

        // random vectors, a metric per phase, some left open across the switch
        for (int ph = 0; ph < 6; ph++) begin
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            write_mode(logic'($urandom_range(0, 1)));
            phase_items = 0;
            if (ph == 2) begin
                // receiver holds off while short vectors keep arriving
                idle_max = 5;
                for (int k = 0; k < 40; k++) queue_vector(1, 1'b1);
                phase_items = 40;
                hold_left = 150;
            end
            while (phase_items < 90) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(1, 6);
                queue_vector(len, 1'b1);
                phase_items += len;
            end
            if ($urandom_range(0, 2) == 0) queue_vector($urandom_range(1, 4), 1'b0);
            settle();
        end

        if (expected_scores.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_scores.size()));
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule
